// ----- sv/egr_pkg.sv -----
package egr_pkg;

	localparam int SIDE_W    = 13;
	localparam int IDX_W     = 12;
	localparam int COEF_W    = 32;
	localparam int AMP_W     = 16;
	localparam int REG_IDX_W = 3;
	localparam int ACC_W     = 60;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int Q30_W     = 30;

	typedef logic signed [MUL_W-1:0]  mul_op_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [REG_IDX_W-1:0]     reg_idx_t;
	typedef logic [3:0]               div_k_t;

	localparam reg_idx_t REG_IMAGE_SIDE  = 3'd0;
	localparam reg_idx_t REG_CENTER_ROW  = 3'd1;
	localparam reg_idx_t REG_CENTER_COL  = 3'd2;
	localparam reg_idx_t REG_COEF_ROW_SQ = 3'd3;
	localparam reg_idx_t REG_COEF_CROSS  = 3'd4;
	localparam reg_idx_t REG_COEF_COL_SQ = 3'd5;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

	localparam div_k_t K_FIRST = 4'd8;
	localparam div_k_t K_LAST  = 4'd1;

	// ceil(2^33 / k) for the divisors that are not powers of two
	function automatic logic [31:0] recip_k(input div_k_t k);
		logic [31:0] r;
		begin
			case (k)
				4'd3:    r = 32'd2863311531;
				4'd5:    r = 32'd1717986919;
				4'd6:    r = 32'd1431655766;
				4'd7:    r = 32'd1227133514;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic is_pow2_k(input div_k_t k);
		return (k == 4'd1) || (k == 4'd2) || (k == 4'd4) || (k == 4'd8);
	endfunction

	function automatic logic [1:0] log2_k(input div_k_t k);
		logic [1:0] s;
		begin
			case (k)
				4'd2:    s = 2'd1;
				4'd4:    s = 2'd2;
				4'd8:    s = 2'd3;
				default: s = 2'd0;
			endcase
			return s;
		end
	endfunction

endpackage

// ----- sv/elliptical_gaussian_raster.sv -----
// Elliptical Gaussian image generator: every accepted input transfer yields one pixel of a
// square image in raster order (column fastest), with amplitude exp(-q) in unsigned
// Q1.AMP_FRAC_BITS where q = A*dr^2 + B*dr*dc + C*dc^2 about the configured centre, and 0 once
// q reaches 16. A single registered 33x33 signed multiplier under a small sequencer does all
// the arithmetic: six products for the quadratic form, two for the base-2 range reduction
// and an eight-step Horner series (two multiplies on steps that divide by 3, 5, 6 or 7). The
// range reduction and the series are skipped when q is negative (amplitude 1.0) or 16 or
// more (amplitude 0). The input side is ready only while idle; the output register holds a
// finished pixel while the next one is computed. A restart of 1 moves the raster to row 0,
// column 0 before that pixel; image_done marks the last pixel of the image. Write
// configuration only while idle.
module elliptical_gaussian_raster #(
	parameter int MAX_SIDE       = 4096,
	parameter int AMP_FRAC_BITS  = 15,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [egr_pkg::REG_IDX_W-1:0]          wr_index,
	input  logic [egr_pkg::COEF_W-1:0]             wr_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   restart,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [egr_pkg::AMP_W-1:0]              amplitude,
	output logic [egr_pkg::IDX_W-1:0]              pixel_row,
	output logic [egr_pkg::IDX_W-1:0]              pixel_col,
	output logic                                   image_done
);
	import egr_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RR    = 4'd1;
	localparam logic [3:0] ST_A     = 4'd2;
	localparam logic [3:0] ST_RC    = 4'd3;
	localparam logic [3:0] ST_B     = 4'd4;
	localparam logic [3:0] ST_CC    = 4'd5;
	localparam logic [3:0] ST_C     = 4'd6;
	localparam logic [3:0] ST_SUM   = 4'd7;
	localparam logic [3:0] ST_L2E   = 4'd8;
	localparam logic [3:0] ST_LN2   = 4'd9;
	localparam logic [3:0] ST_Y     = 4'd10;
	localparam logic [3:0] ST_HMUL  = 4'd11;
	localparam logic [3:0] ST_HDIV  = 4'd12;
	localparam logic [3:0] ST_HFIX  = 4'd13;
	localparam logic [3:0] ST_ROUND = 4'd14;
	localparam logic [3:0] ST_OUT   = 4'd15;

	localparam int SIDE_LIM_I = (MAX_SIDE < 4096) ? MAX_SIDE : 4096;
	localparam logic [SIDE_W-1:0] SIDE_LIM = SIDE_W'(SIDE_LIM_I);
	localparam int QS_W = COEF_FRAC_BITS + 18;
	localparam int SH_BASE = 30 - AMP_FRAC_BITS;
	localparam logic [31:0] AMP_ONE_FULL = 32'd1 << AMP_FRAC_BITS;
	localparam logic [AMP_W-1:0] AMP_ONE = AMP_ONE_FULL[AMP_W-1:0];
	localparam int RND_W = 48;

	// configuration
	logic [SIDE_W-1:0]        side_q;
	logic [IDX_W-1:0]         crow_q;
	logic [IDX_W-1:0]         ccol_q;
	logic [COEF_W-1:0]        coef_a_q;
	logic signed [COEF_W-1:0] coef_b_q;
	logic [COEF_W-1:0]        coef_c_q;

	// raster and sequencer
	logic [IDX_W-1:0]        row_cnt_q;
	logic [IDX_W-1:0]        col_cnt_q;
	logic [3:0]              state_q;
	logic signed [IDX_W:0]   dr_q;
	logic signed [IDX_W:0]   dc_q;
	logic [IDX_W-1:0]        prow_q;
	logic [IDX_W-1:0]        pcol_q;
	logic                    pdone_q;
	prod_t                   prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [4:0]              n_q;
	logic [Q30_W-1:0]        y_q;
	logic [Q30_W:0]          p_q;
	div_k_t                  k_q;
	logic [AMP_W-1:0]        amp_q;

	// output register
	logic                    out_valid_q;
	logic [AMP_W-1:0]        amplitude_q;
	logic [IDX_W-1:0]        pixel_row_q;
	logic [IDX_W-1:0]        pixel_col_q;
	logic                    image_done_q;

	logic                    in_xfer;
	logic                    out_xfer;
	logic                    out_load;
	logic [IDX_W-1:0]        row_cur;
	logic [IDX_W-1:0]        col_cur;
	logic [SIDE_W-1:0]       side_eff;
	logic                    last_col;
	logic                    last_row;
	mul_op_t                 mul_a;
	mul_op_t                 mul_b;
	prod_t                   mul_p;
	logic [QS_W-1:0]         qs_wide;
	logic                    q_neg;
	logic                    q_big;
	logic [Q30_W-1:0]        x_div;
	logic [Q30_W-1:0]        quot_fix;
	logic [5:0]              sh;
	logic [RND_W-1:0]        rnd_sum;
	logic [RND_W-1:0]        rnd;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign out_xfer   = out_valid_q && !out_stall;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign amplitude  = amplitude_q;
	assign pixel_row  = pixel_row_q;
	assign pixel_col  = pixel_col_q;
	assign image_done = image_done_q;

	// raster position of the pixel being taken in
	always_comb begin
		row_cur  = restart ? '0 : row_cnt_q;
		col_cur  = restart ? '0 : col_cnt_q;
		side_eff = side_q;
		if (side_q == '0) begin
			side_eff = SIDE_W'(1);
		end else if (side_q > SIDE_LIM) begin
			side_eff = SIDE_LIM;
		end
		last_col = ({1'b0, col_cur} + SIDE_W'(1)) >= side_eff;
		last_row = ({1'b0, row_cur} + SIDE_W'(1)) >= side_eff;
	end

	// derived values from the product and accumulator
	always_comb begin
		qs_wide  = {acc_q[COEF_FRAC_BITS+3:0], 14'd0} >> (COEF_FRAC_BITS - 10);
		q_neg    = acc_q[ACC_W-1];
		q_big    = |acc_q[ACC_W-2:COEF_FRAC_BITS+4];
		x_div    = prod_q[59:30];
		quot_fix = prod_q[62:33];
		sh       = 6'(SH_BASE) + {1'b0, n_q};
		rnd_sum  = {{(RND_W-Q30_W-1){1'b0}}, p_q} + (RND_W'(1) << (sh - 6'd1));
		rnd      = rnd_sum >> sh;
	end

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RR: begin
				mul_a = MUL_W'(dr_q);
				mul_b = MUL_W'(dr_q);
			end
			ST_A: begin
				mul_a = $signed({1'b0, coef_a_q});
				mul_b = $signed(prod_q[MUL_W-1:0]);
			end
			ST_RC: begin
				mul_a = MUL_W'(dr_q);
				mul_b = MUL_W'(dc_q);
			end
			ST_B: begin
				mul_a = MUL_W'(coef_b_q);
				mul_b = $signed(prod_q[MUL_W-1:0]);
			end
			ST_CC: begin
				mul_a = MUL_W'(dc_q);
				mul_b = MUL_W'(dc_q);
			end
			ST_C: begin
				mul_a = $signed({1'b0, coef_c_q});
				mul_b = $signed(prod_q[MUL_W-1:0]);
			end
			ST_L2E: begin
				mul_a = $signed({5'd0, qs_wide[27:0]});
				mul_b = $signed({2'd0, LOG2E_Q30});
			end
			ST_LN2: begin
				mul_a = $signed({9'd0, prod_q[53:30]});
				mul_b = $signed({3'd0, LN2_Q30});
			end
			ST_HMUL: begin
				mul_a = $signed({3'd0, y_q});
				mul_b = $signed({2'd0, p_q});
			end
			ST_HDIV: begin
				mul_a = $signed({3'd0, x_div});
				mul_b = $signed({1'b0, recip_k(k_q)});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q   <= SIDE_W'(1024);
			crow_q   <= IDX_W'(512);
			ccol_q   <= IDX_W'(512);
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_SIDE:  side_q   <= wr_data[SIDE_W-1:0];
				REG_CENTER_ROW:  crow_q   <= wr_data[IDX_W-1:0];
				REG_CENTER_COL:  ccol_q   <= wr_data[IDX_W-1:0];
				REG_COEF_ROW_SQ: coef_a_q <= wr_data;
				REG_COEF_CROSS:  coef_b_q <= $signed(wr_data);
				REG_COEF_COL_SQ: coef_c_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_cnt_q <= '0;
			col_cnt_q <= '0;
			k_q       <= K_FIRST;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (last_col) begin
							col_cnt_q <= '0;
							row_cnt_q <= last_row ? '0 : row_cur + IDX_W'(1);
						end else begin
							row_cnt_q <= row_cur;
							col_cnt_q <= col_cur + IDX_W'(1);
						end
						state_q <= ST_RR;
					end
				end
				ST_RR:  state_q <= ST_A;
				ST_A:   state_q <= ST_RC;
				ST_RC:  state_q <= ST_B;
				ST_B:   state_q <= ST_CC;
				ST_CC:  state_q <= ST_C;
				ST_C:   state_q <= ST_SUM;
				ST_SUM: state_q <= ST_L2E;
				ST_L2E: begin
					state_q <= (q_neg || q_big) ? ST_OUT : ST_LN2;
				end
				ST_LN2: state_q <= ST_Y;
				ST_Y: begin
					k_q     <= K_FIRST;
					state_q <= ST_HMUL;
				end
				ST_HMUL: state_q <= ST_HDIV;
				ST_HDIV: begin
					if (!is_pow2_k(k_q)) begin
						state_q <= ST_HFIX;
					end else if (k_q == K_LAST) begin
						state_q <= ST_ROUND;
					end else begin
						k_q     <= k_q - div_k_t'(1);
						state_q <= ST_HMUL;
					end
				end
				ST_HFIX: begin
					k_q     <= k_q - div_k_t'(1);
					state_q <= ST_HMUL;
				end
				ST_ROUND: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					dr_q    <= $signed({1'b0, row_cur}) - $signed({1'b0, crow_q});
					dc_q    <= $signed({1'b0, col_cur}) - $signed({1'b0, ccol_q});
					prow_q  <= row_cur;
					pcol_q  <= col_cur;
					pdone_q <= last_col && last_row;
				end
			end
			ST_RC:  acc_q <= prod_q[ACC_W-1:0];
			ST_CC:  acc_q <= acc_q + prod_q[ACC_W-1:0];
			ST_SUM: acc_q <= acc_q + prod_q[ACC_W-1:0];
			ST_L2E: begin
				if (q_neg) begin
					amp_q <= AMP_ONE;
				end else if (q_big) begin
					amp_q <= '0;
				end
			end
			ST_LN2: n_q <= prod_q[58:54];
			ST_Y: begin
				y_q <= prod_q[53:24];
				p_q <= ONE_Q30;
			end
			ST_HDIV: begin
				if (is_pow2_k(k_q)) begin
					p_q <= ONE_Q30 - {1'b0, x_div >> log2_k(k_q)};
				end
			end
			ST_HFIX:  p_q   <= ONE_Q30 - {1'b0, quot_fix};
			ST_ROUND: amp_q <= rnd[AMP_W-1:0];
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			amplitude_q  <= amp_q;
			pixel_row_q  <= prow_q;
			pixel_col_q  <= pcol_q;
			image_done_q <= pdone_q;
		end
	end

	// checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while a pixel is in progress");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("output loaded outside the output step");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HMUL) |-> (k_q >= K_LAST && k_q <= K_FIRST))
		else $error("series divisor out of range");

	a_amp_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((AMP_FRAC_BITS > 15) || (amplitude_q <= AMP_ONE)))
		else $error("amplitude above one");

endmodule

// ----- verif/elliptical_gaussian_raster_tb.sv -----
`timescale 1ns / 1ps

module elliptical_gaussian_raster_tb;
	import egr_pkg::*;

	localparam int MAX_SIDE       = 4096;
	localparam int AMP_FRAC       = 15;
	localparam int COEF_FRAC      = 28;
	localparam int ITEMS          = 1150;
	localparam int SETTLE_CYCLES  = 48;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 48;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 100;

	localparam reg_idx_t REG_SPARE_LO = 3'd6;
	localparam reg_idx_t REG_SPARE_HI = 3'd7;

	typedef longint unsigned u64_t;

	localparam u64_t   LOG2E_FX = 64'd1549082005;
	localparam u64_t   LN2_FX   = 64'd744261118;
	localparam u64_t   ONE_FX   = 64'd1 << 30;
	localparam longint Q_LIMIT  = 64'sd16 <<< COEF_FRAC;
	localparam int     AMP_ONE  = 1 << AMP_FRAC;

	typedef enum logic [2:0] {JOB_PIXEL, JOB_WRITE, JOB_DRAIN, JOB_PACE, JOB_HOLD} job_kind_t;

	typedef struct {
		job_kind_t   kind;
		logic        rst;
		reg_idx_t    idx;
		logic [31:0] data;
		int          snd_pct;
		int          rcv_pct;
	} job_t;

	typedef struct packed {
		logic [AMP_W-1:0] amp;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             done;
	} pixel_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                wr_en      = 1'b0;
	reg_idx_t            wr_index   = '0;
	logic [COEF_W-1:0]   wr_data    = '0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic                restart    = 1'b0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [AMP_W-1:0]    amplitude;
	logic [IDX_W-1:0]    pixel_row;
	logic [IDX_W-1:0]    pixel_col;
	logic                image_done;

	// predicted block state and register copies
	logic [SIDE_W-1:0]   m_side = 13'd1024;
	logic [IDX_W-1:0]    m_crow = 12'd512;
	logic [IDX_W-1:0]    m_ccol = 12'd512;
	logic [COEF_W-1:0]   m_a    = '0;
	logic [COEF_W-1:0]   m_b    = '0;
	logic [COEF_W-1:0]   m_c    = '0;
	logic [IDX_W-1:0]    m_row  = '0;
	logic [IDX_W-1:0]    m_col  = '0;

	job_t   jobs[$];
	pixel_t pixel_q[$];

	int planned     = 0;
	int err_cnt     = 0;
	int sent_total  = 0;
	int n_sent      = 0;
	int n_done      = 0;
	int quiet       = 0;
	int snd_pct     = 0;
	int rcv_pct     = 0;
	int hold_seq    = 0;
	int hold_seen   = 0;
	int hold_left   = 0;
	int idle_cycles = 0;

	elliptical_gaussian_raster DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.amplitude  (amplitude),
		.pixel_row  (pixel_row),
		.pixel_col  (pixel_col),
		.image_done (image_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("mismatch: %s got %0d expected %0d", what, got, want);
	endtask

	function automatic logic [AMP_W-1:0] gauss_amp(input longint q);
		u64_t qs, t, n, f, y, p, rnd;
		int   k, sh;
		if (q < 0)
			return AMP_W'(AMP_ONE);
		if (q >= Q_LIMIT)
			return '0;
		qs = (u64_t'(q) << 14) >> (COEF_FRAC - 10);
		t  = (qs * LOG2E_FX) >> 30;
		n  = t >> 24;
		f  = t & ((64'd1 << 24) - 1);
		y  = (f * LN2_FX) >> 24;
		p  = ONE_FX;
		for (k = 8; k >= 1; k--)
			p = ONE_FX - ((y * p) >> 30) / u64_t'(k);
		sh  = 30 - AMP_FRAC + int'(n);
		rnd = (p + (64'd1 << (sh - 1))) >> sh;
		return rnd[AMP_W-1:0];
	endfunction

	task automatic raster_next(input logic rst);
		pixel_t px;
		int     side_eff;
		longint dr, dc, b, q;
		logic   lc, lr;
		if (rst) begin
			m_row = '0;
			m_col = '0;
		end
		side_eff = int'(m_side);
		if (side_eff < 1)
			side_eff = 1;
		if (side_eff > MAX_SIDE)
			side_eff = MAX_SIDE;
		dr = longint'(m_row) - longint'(m_crow);
		dc = longint'(m_col) - longint'(m_ccol);
		b  = longint'(signed'(m_b));
		q  = longint'(m_a) * (dr * dr) + b * (dr * dc) + longint'(m_c) * (dc * dc);
		lc = (int'(m_col) + 1 >= side_eff);
		lr = (int'(m_row) + 1 >= side_eff);
		px.amp  = gauss_amp(q);
		px.row  = m_row;
		px.col  = m_col;
		px.done = lc && lr;
		pixel_q.push_back(px);
		if (lc) begin
			m_col = '0;
			m_row = lr ? '0 : m_row + 1'b1;
		end else begin
			m_col = m_col + 1'b1;
		end
	endtask

	task automatic apply_write(input reg_idx_t idx, input logic [31:0] d);
		case (idx)
			REG_IMAGE_SIDE:  m_side = d[SIDE_W-1:0];
			REG_CENTER_ROW:  m_crow = d[IDX_W-1:0];
			REG_CENTER_COL:  m_ccol = d[IDX_W-1:0];
			REG_COEF_ROW_SQ: m_a    = d;
			REG_COEF_CROSS:  m_b    = d;
			REG_COEF_COL_SQ: m_c    = d;
			default: ;
		endcase
	endtask

	task automatic queue_pixel(input logic rst);
		job_t j;
		j = '{kind: JOB_PIXEL, rst: rst, idx: '0, data: '0, snd_pct: 0, rcv_pct: 0};
		jobs.push_back(j);
		planned++;
	endtask

	task automatic queue_write(input reg_idx_t idx, input logic [31:0] d);
		job_t j;
		j = '{kind: JOB_WRITE, rst: 1'b0, idx: idx, data: d, snd_pct: 0, rcv_pct: 0};
		jobs.push_back(j);
	endtask

	task automatic queue_drain();
		job_t j;
		j = '{kind: JOB_DRAIN, rst: 1'b0, idx: '0, data: '0, snd_pct: 0, rcv_pct: 0};
		jobs.push_back(j);
	endtask

	task automatic queue_pace(input int s, input int r);
		job_t j;
		j = '{kind: JOB_PACE, rst: 1'b0, idx: '0, data: '0, snd_pct: s, rcv_pct: r};
		jobs.push_back(j);
	endtask

	task automatic queue_hold();
		job_t j;
		j = '{kind: JOB_HOLD, rst: 1'b0, idx: '0, data: '0, snd_pct: 0, rcv_pct: 0};
		jobs.push_back(j);
	endtask

	function automatic logic [31:0] pick_coef(input u64_t lim, input logic sgn);
		logic [31:0] v;
		int          r;
		r = $urandom_range(99);
		if (r < 70) begin
			v = $urandom_range(0, lim[31:0]);
			if (sgn && $urandom_range(1) == 1)
				v = -v;
		end else if (r < 85) begin
			v = $urandom();
		end else begin
			case ($urandom_range(3))
				0:       v = 32'h0000_0000;
				1:       v = 32'hFFFF_FFFF;
				2:       v = 32'h8000_0000;
				default: v = 32'h7FFF_FFFF;
			endcase
		end
		return v;
	endfunction

	// input side: pixel transfers, register writes and pacing control
	always @(posedge clk or negedge arst_n) begin : item_driver
		logic        take;
		logic        nv;
		logic        nr;
		logic        nw;
		reg_idx_t    ni;
		logic [31:0] nd;
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart  <= 1'b0;
			wr_en    <= 1'b0;
			wr_index <= '0;
			wr_data  <= '0;
		end else begin
			take = in_valid && !in_stall;
			if (take) begin
				raster_next(restart);
				sent_total++;
			end
			nv = in_valid && !take;
			nr = restart;
			nw = 1'b0;
			ni = wr_index;
			nd = wr_data;
			if (!nv && jobs.size() != 0) begin
				case (jobs[0].kind)
					JOB_PIXEL: begin
						if ($urandom_range(99) >= snd_pct) begin
							nv = 1'b1;
							nr = jobs[0].rst;
							jobs.delete(0);
						end
					end
					JOB_WRITE: begin
						// block must be idle before its registers change
						if (sent_total == n_done && quiet >= SETTLE_CYCLES) begin
							nw = 1'b1;
							ni = jobs[0].idx;
							nd = jobs[0].data;
							apply_write(ni, nd);
							jobs.delete(0);
						end
					end
					JOB_DRAIN: begin
						if (sent_total == n_done)
							jobs.delete(0);
					end
					JOB_PACE: begin
						snd_pct = jobs[0].snd_pct;
						rcv_pct <= jobs[0].rcv_pct;
						jobs.delete(0);
					end
					default: begin
						hold_seq <= hold_seq + 1;
						jobs.delete(0);
					end
				endcase
			end
			if (sent_total == n_done && !nv)
				quiet++;
			else
				quiet = 0;
			in_valid <= nv;
			restart  <= nr;
			wr_en    <= nw;
			wr_index <= ni;
			wr_data  <= nd;
			n_sent   <= sent_total;
		end
	end

	// output side stall, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin : result_sink
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (n_done >= n_sent) begin
				report($sformatf("pixel transfer with nothing predicted at (%0d,%0d)",
					pixel_row, pixel_col), amplitude, 0);
			end else begin
				want = pixel_q.pop_front();
				if (amplitude !== want.amp)
					report($sformatf("amplitude at (%0d,%0d)", want.row, want.col),
						amplitude, want.amp);
				if (pixel_row !== want.row)
					report("pixel_row", pixel_row, want.row);
				if (pixel_col !== want.col)
					report("pixel_col", pixel_col, want.col);
				if (image_done !== want.done)
					report($sformatf("image_done at (%0d,%0d)", want.row, want.col),
						image_done, want.done);
				n_done <= n_done + 1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** elliptical_gaussian_raster: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int          r, i, npix, stage, want_side, plan_side;
		u64_t        lim;
		logic [31:0] d;
		stage = 0;

		queue_pace(20, 55);

		// reset registers: flat zero form gives full amplitude
		queue_pixel(1'b1);
		queue_pixel(1'b0);

		// q just below 16 and q at the zero threshold
		queue_write(REG_IMAGE_SIDE, 32'd5);
		queue_write(REG_CENTER_ROW, 32'd0);
		queue_write(REG_CENTER_COL, 32'd2);
		queue_write(REG_COEF_ROW_SQ, 32'h4000_0000);
		queue_write(REG_COEF_CROSS, 32'h0000_0000);
		queue_write(REG_COEF_COL_SQ, 32'h3FFF_FFFF);
		queue_pixel(1'b1);
		for (i = 0; i < 4; i++)
			queue_pixel(1'b0);
		queue_write(REG_COEF_COL_SQ, 32'h4000_0000);
		queue_pixel(1'b1);

		// indefinite form: negative q saturates, then the largest coefficients
		queue_write(REG_IMAGE_SIDE, 32'd2);
		queue_write(REG_CENTER_ROW, 32'd1);
		queue_write(REG_CENTER_COL, 32'd1);
		queue_write(REG_COEF_ROW_SQ, 32'h0000_0000);
		queue_write(REG_COEF_COL_SQ, 32'h0000_0000);
		queue_write(REG_COEF_CROSS, 32'h8000_0000);
		queue_pixel(1'b1);
		queue_pixel(1'b0);
		queue_write(REG_COEF_CROSS, 32'h7FFF_FFFF);
		queue_write(REG_COEF_ROW_SQ, 32'hFFFF_FFFF);
		queue_write(REG_COEF_COL_SQ, 32'hFFFF_FFFF);
		queue_pixel(1'b0);
		queue_pixel(1'b0);

		// side of zero clamps to one, oversized side clamps to the maximum
		queue_write(REG_IMAGE_SIDE, 32'd0);
		queue_pixel(1'b0);
		queue_pixel(1'b0);
		queue_write(REG_IMAGE_SIDE, 32'hFFFF_FFFF);
		queue_write(REG_CENTER_ROW, 32'hFFFF_FFFF);
		queue_write(REG_CENTER_COL, 32'd0);
		queue_write(REG_SPARE_LO, $urandom());
		queue_write(REG_SPARE_HI, $urandom());
		queue_pixel(1'b1);
		queue_pixel(1'b0);

		// side shrunk with the counters already past it
		queue_write(REG_IMAGE_SIDE, 32'd4);
		queue_write(REG_CENTER_ROW, 32'd2);
		queue_write(REG_CENTER_COL, 32'd1);
		queue_write(REG_COEF_ROW_SQ, 32'h0400_0000);
		queue_write(REG_COEF_CROSS, 32'hF800_0000);
		queue_write(REG_COEF_COL_SQ, 32'h0200_0000);
		queue_pixel(1'b1);
		for (i = 0; i < 8; i++)
			queue_pixel(1'b0);
		queue_write(REG_IMAGE_SIDE, 32'd2);
		for (i = 0; i < 3; i++)
			queue_pixel(1'b0);
		plan_side = 2;

		queue_hold();

		while (planned < ITEMS) begin
			if (stage == 0 && planned >= ITEMS / 3) begin
				queue_pace(55, 20);
				queue_hold();
				stage = 1;
			end else if (stage == 1 && planned >= 2 * ITEMS / 3) begin
				queue_pace(0, 0);
				queue_hold();
				stage = 2;
			end

			r = $urandom_range(99);
			if (r < 75)
				want_side = $urandom_range(1, 16);
			else if (r < 87)
				want_side = $urandom_range(17, 64);
			else
				want_side = MAX_SIDE;
			if ($urandom_range(3) != 0) begin
				d = $urandom();
				if ($urandom_range(2) != 0)
					d[31:SIDE_W] = '0;
				if (want_side == MAX_SIDE && $urandom_range(1) == 1)
					d[SIDE_W-1:0] = SIDE_W'($urandom_range(MAX_SIDE + 1, 8191));
				else if (want_side == 1 && $urandom_range(1) == 1)
					d[SIDE_W-1:0] = '0;
				else
					d[SIDE_W-1:0] = SIDE_W'(want_side);
				queue_write(REG_IMAGE_SIDE, d);
				plan_side = want_side;
			end
			if ($urandom_range(3) != 0) begin
				d = $urandom();
				if ($urandom_range(2) != 0)
					d[31:IDX_W] = '0;
				d[IDX_W-1:0] = ($urandom_range(9) < 7) ?
					IDX_W'($urandom_range(0, plan_side - 1)) : IDX_W'($urandom());
				queue_write(REG_CENTER_ROW, d);
			end
			if ($urandom_range(3) != 0) begin
				d = $urandom();
				if ($urandom_range(2) != 0)
					d[31:IDX_W] = '0;
				d[IDX_W-1:0] = ($urandom_range(9) < 7) ?
					IDX_W'($urandom_range(0, plan_side - 1)) : IDX_W'($urandom());
				queue_write(REG_CENTER_COL, d);
			end

			// scale so that a square term at the limit reaches roughly 64 across the image
			lim = (64'd1 << 34) / u64_t'(plan_side * plan_side);
			if (lim > 64'hFFFF_FFFF)
				lim = 64'hFFFF_FFFF;
			if ($urandom_range(3) != 0)
				queue_write(REG_COEF_ROW_SQ, pick_coef(lim, 1'b0));
			if ($urandom_range(3) != 0)
				queue_write(REG_COEF_CROSS, pick_coef(lim / 2, 1'b1));
			if ($urandom_range(3) != 0)
				queue_write(REG_COEF_COL_SQ, pick_coef(lim, 1'b0));
			if ($urandom_range(19) == 0)
				queue_write(($urandom_range(1) == 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());

			if ($urandom_range(99) < 45 && plan_side <= 12)
				npix = plan_side * plan_side * $urandom_range(1, 2);
			else
				npix = $urandom_range(8, 48);
			if (npix > ITEMS - planned)
				npix = ITEMS - planned;
			for (i = 0; i < npix; i++) begin
				if (i == npix / 2 && $urandom_range(9) == 0)
					queue_drain();
				if (i == 0)
					queue_pixel(1'($urandom_range(1)));
				else
					queue_pixel($urandom_range(99) < 3);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (jobs.size() != 0 || in_valid || n_sent != n_done)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pixel_q.size() != 0)
			report("predicted pixels never transferred", pixel_q.size(), 0);

		if (err_cnt == 0)
			$display("** elliptical_gaussian_raster: PASSED **");
		else
			$display("** elliptical_gaussian_raster: FAILED **");
		$finish;
	end

endmodule
